// ===== design/sisa_pkg.sv =====
// Shared types, constants and the slot period table of the serial id slot allocator.
`timescale 1ns / 1ps
package sisa_pkg;

    localparam int NUM_CORES  = 8;
    localparam int CORE_AW    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int CORE_ID_W  = 3;
    localparam int ID_W       = 64;
    localparam int EPOCH_W    = 32;
    localparam int SEQ_W      = 24;
    localparam int NODE_W     = 8;
    localparam int BACKOFF_W  = 24;
    localparam int PCT_W      = 7;
    localparam int K_W        = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_CNT_W  = $clog2(SEQ_W + 1);

    localparam logic [BACKOFF_W-1:0] BACKOFF_RESET  = BACKOFF_W'(100);
    localparam logic [PCT_W-1:0]     PCT_RESET      = PCT_W'(20);
    localparam logic                 PRIO_RESET     = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BACKOFF  = 2'd0,
        CFG_SLOT_PCT = 2'd1,
        CFG_PRIORITY = 2'd2,
        CFG_NONE     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FUNC_UPDATE       = 2'd0,
        FUNC_ALLOCATE     = 2'd1,
        FUNC_CHECK_PASSED = 2'd2,
        FUNC_CHECK_SLOT   = 2'd3
    } t_func;

    typedef struct packed {
        t_func                func;
        logic [CORE_ID_W-1:0] core_id;
        logic [ID_W-1:0]      value;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0] issued_id;
        logic            flag;
        logic            epoch_advanced;
        logic [ID_W-1:0] max_progress;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [SEQ_W-1:0] dividend;
        logic [K_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [K_W-1:0] rem;
    } t_div_rsp;

    // Slot period 100 / pct + 1, with zero taken as one.
    function automatic logic [K_W-1:0] slot_period(input logic [PCT_W-1:0] pct);
        logic [K_W-1:0] k;
        if (pct <= PCT_W'(1))        k = K_W'(101);
        else if (pct == PCT_W'(2))   k = K_W'(51);
        else if (pct == PCT_W'(3))   k = K_W'(34);
        else if (pct == PCT_W'(4))   k = K_W'(26);
        else if (pct == PCT_W'(5))   k = K_W'(21);
        else if (pct == PCT_W'(6))   k = K_W'(17);
        else if (pct == PCT_W'(7))   k = K_W'(15);
        else if (pct == PCT_W'(8))   k = K_W'(13);
        else if (pct == PCT_W'(9))   k = K_W'(12);
        else if (pct == PCT_W'(10))  k = K_W'(11);
        else if (pct == PCT_W'(11))  k = K_W'(10);
        else if (pct == PCT_W'(12))  k = K_W'(9);
        else if (pct <= PCT_W'(14))  k = K_W'(8);
        else if (pct <= PCT_W'(16))  k = K_W'(7);
        else if (pct <= PCT_W'(20))  k = K_W'(6);
        else if (pct <= PCT_W'(25))  k = K_W'(5);
        else if (pct <= PCT_W'(33))  k = K_W'(4);
        else if (pct <= PCT_W'(50))  k = K_W'(3);
        else if (pct <= PCT_W'(100)) k = K_W'(2);
        else                         k = K_W'(1);
        return k;
    endfunction

endpackage

// ===== design/sisa_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module sisa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sisa_div.sv =====
// Bit-serial remainder unit: sequence modulo slot period, one dividend bit per cycle.
`timescale 1ns / 1ps
module sisa_div
    import sisa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SEQ_W-1:0]     r_dvd;
    logic [K_W-1:0]       r_div;
    logic [K_W-1:0]       r_rem;

    logic [K_W:0]   shifted;
    logic [K_W-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_dvd[SEQ_W-1]};
        if (shifted >= {1'b0, r_div}) begin
            n_rem = K_W'(shifted - {1'b0, r_div});
        end else begin
            n_rem = K_W'(shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(SEQ_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            // shift in the next dividend bit and reduce
            r_dvd <= {r_dvd[SEQ_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== design/serial_id_slot_allocator.sv =====
// Serial id slot allocator: per-core progress table in RAM, id allocation and slot checks.
// Update and check-passed do not use the divider; allocate and check-slot first wait on
// the 24-step bit-serial remainder unit.
// One transaction in flight: a new one is taken only after the result registers.
// Synchronous active-low reset clears the progress table (per-entry valid bits), the
// last issued id, the epoch and the maximum; registers return to 100, 20 and 1.
`timescale 1ns / 1ps
module serial_id_slot_allocator
    import sisa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FIN
    } t_state;

    t_state                r_state, n_state;
    logic [BACKOFF_W-1:0]  r_cfg_backoff;
    logic [PCT_W-1:0]      r_cfg_pct;
    logic                  r_cfg_prio;
    logic [NUM_CORES-1:0]  r_vld;
    logic [ID_W-1:0]       r_max, n_max;
    logic [ID_W-1:0]       r_last, n_last;
    logic [EPOCH_W-1:0]    r_epoch, n_epoch;
    t_in_item              r_req;
    logic [ID_W-1:0]       r_lb, n_lb;
    logic [ID_W-1:0]       r_res_id, n_res_id;
    logic                  r_res_flag, n_res_flag;
    logic                  r_res_adv, n_res_adv;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  accept;
    logic                  out_free;
    logic [CORE_AW-1:0]    addr;
    logic                  in_range;
    logic [ID_W-1:0]       rdata;
    logic [ID_W-1:0]       entry;
    logic                  do_write;
    logic [K_W-1:0]        k;
    logic [SEQ_W:0]        bumped;
    logic [ID_W-1:0]       cand;
    logic [SEQ_W:0]        slot_seq;
    t_div_req              div_req;
    t_div_rsp              div_rsp;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign addr       = CORE_AW'(r_req.core_id);
    assign in_range   = (7'(r_req.core_id) < 7'(NUM_CORES));
    assign entry      = r_vld[addr] ? rdata : '0;
    assign k          = slot_period(r_cfg_pct);
    assign do_write   = (r_state == S_EXEC) && (r_req.func == FUNC_UPDATE) && in_range
                        && (r_req.value > entry);

    sisa_ram #(
        .WIDTH (ID_W),
        .DEPTH (NUM_CORES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (addr),
        .i_wdata (r_req.value),
        .i_re    (accept),
        .i_raddr (CORE_AW'(i_in_data.core_id)),
        .o_rdata (rdata)
    );

    sisa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state    = r_state;
        n_max      = r_max;
        n_last     = r_last;
        n_epoch    = r_epoch;
        n_lb       = r_lb;
        n_res_id   = r_res_id;
        n_res_flag = r_res_flag;
        n_res_adv  = r_res_adv;
        div_req    = '0;
        div_req.divisor = k;

        // lower bound: fastest progress moved ahead by the backoff, sequence carry ORs into epoch
        bumped = (SEQ_W + 1)'(r_max[NODE_W +: SEQ_W]) + (SEQ_W + 1)'(r_cfg_backoff);
        cand   = {r_max[ID_W-1 -: EPOCH_W] | EPOCH_W'(bumped[SEQ_W]),
                  bumped[SEQ_W-1:0], r_max[NODE_W-1:0]};
        slot_seq = (SEQ_W + 1)'(r_lb[NODE_W +: SEQ_W]) - (SEQ_W + 1)'(div_rsp.rem)
                   + (SEQ_W + 1)'(k);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_id   = '0;
                n_res_flag = 1'b0;
                n_res_adv  = 1'b0;
                unique case (r_req.func)
                    FUNC_UPDATE: begin
                        if (do_write) begin
                            if ((r_req.value[ID_W-1 -: EPOCH_W] > entry[ID_W-1 -: EPOCH_W])
                                && (r_epoch == entry[ID_W-1 -: EPOCH_W])) begin
                                n_epoch   = r_req.value[ID_W-1 -: EPOCH_W];
                                n_res_adv = 1'b1;
                            end
                            if (r_req.value > r_max) begin
                                n_max = r_req.value;
                            end
                        end
                        n_state = S_FIN;
                    end
                    FUNC_ALLOCATE: begin
                        n_lb = (r_last > cand) ? r_last : cand;
                        div_req.start    = 1'b1;
                        div_req.dividend = n_lb[NODE_W +: SEQ_W];
                        n_state = S_DIV;
                    end
                    FUNC_CHECK_PASSED: begin
                        // entries only grow, so the running maximum answers this
                        n_res_flag = (r_max > r_req.value);
                        n_state    = S_FIN;
                    end
                    FUNC_CHECK_SLOT: begin
                        div_req.start    = 1'b1;
                        div_req.dividend = r_req.value[NODE_W +: SEQ_W];
                        n_state = S_DIV;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (r_req.func == FUNC_ALLOCATE) begin
                        // round the sequence up to the next multiple of the period
                        n_res_id = {r_lb[ID_W-1 -: EPOCH_W] | EPOCH_W'(slot_seq[SEQ_W]),
                                    slot_seq[SEQ_W-1:0], r_lb[NODE_W-1:0]};
                        n_last   = n_res_id;
                    end else begin
                        n_res_flag = r_cfg_prio && (r_req.value != '0)
                                     && (div_rsp.rem == '0);
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
                r_out       <= '{issued_id: r_res_id, flag: r_res_flag,
                                 epoch_advanced: r_res_adv, max_progress: r_max};
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_backoff <= BACKOFF_RESET;
            r_cfg_pct     <= PCT_RESET;
            r_cfg_prio    <= PRIO_RESET;
            r_vld         <= '0;
            r_max         <= '0;
            r_last        <= '0;
            r_epoch       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_BACKOFF:  r_cfg_backoff <= i_cfg_data[BACKOFF_W-1:0];
                    CFG_SLOT_PCT: r_cfg_pct     <= i_cfg_data[PCT_W-1:0];
                    CFG_PRIORITY: r_cfg_prio    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (do_write) begin
                r_vld[addr] <= 1'b1;
            end
            r_max   <= n_max;
            r_last  <= n_last;
            r_epoch <= n_epoch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_data;
        end
        r_lb       <= n_lb;
        r_res_id   <= n_res_id;
        r_res_flag <= n_res_flag;
        r_res_adv  <= n_res_adv;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sim/serial_id_slot_allocator_tb.sv =====
// Self-checking testbench for the serial id slot allocator: directed and random test phases.
`timescale 1ns / 1ps
module serial_id_slot_allocator_tb;
    import sisa_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 40;
    localparam int MAX_REPORTS  = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit                    idle_on = 1'b1;
    int                    mismatches = 0;
    int                    cycles = 0;
    t_out_item             pending_results[$];

    // Mirror of the block state and its registers
    logic [ID_W-1:0]       core_progress[NUM_CORES];
    logic [ID_W-1:0]       last_id = '0;
    logic [EPOCH_W-1:0]    cur_epoch = '0;
    logic [BACKOFF_W-1:0]  cfg_backoff = BACKOFF_RESET;
    logic [PCT_W-1:0]      cfg_pct = PCT_RESET;
    logic                  cfg_prio = PRIO_RESET;

    serial_id_slot_allocator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("serial_id_slot_allocator_tb failed");
            $finish;
        end
    end

    function automatic logic [ID_W-1:0] table_peak();
        logic [ID_W-1:0] m;
        m = '0;
        for (int i = 0; i < NUM_CORES; i++)
            if (core_progress[i] > m) m = core_progress[i];
        return m;
    endfunction

    function automatic logic [ID_W-1:0] period_of(input logic [PCT_W-1:0] pct);
        logic [PCT_W-1:0] p;
        p = (pct == '0) ? PCT_W'(1) : pct;
        return ID_W'(100 / p) + 1;
    endfunction

    function automatic t_out_item predict_result(input t_in_item item);
        t_out_item       r;
        logic [ID_W-1:0] m, lb, k, seq, old_ep, new_ep;
        r = '0;
        k = period_of(cfg_pct);
        case (item.func)
            FUNC_UPDATE: begin
                if (item.value > core_progress[item.core_id]) begin
                    old_ep = core_progress[item.core_id] >> 32;
                    new_ep = item.value >> 32;
                    if (new_ep > old_ep && ID_W'(cur_epoch) == old_ep) begin
                        cur_epoch = new_ep[EPOCH_W-1:0];
                        r.epoch_advanced = 1'b1;
                    end
                    core_progress[item.core_id] = item.value;
                end
            end
            FUNC_ALLOCATE: begin
                m  = table_peak();
                // OR composition: a sequence carry lands in the epoch bits
                lb = {m[63:32], 32'h0} | ((ID_W'(m[31:8]) + ID_W'(cfg_backoff)) << 8)
                     | ID_W'(m[7:0]);
                if (last_id > lb) lb = last_id;
                seq = ID_W'(lb[31:8]);
                seq = (seq / k + 1) * k;
                r.issued_id = {lb[63:32], 32'h0} | (seq << 8) | ID_W'(lb[7:0]);
                last_id = r.issued_id;
            end
            FUNC_CHECK_PASSED: begin
                for (int i = 0; i < NUM_CORES; i++)
                    if (core_progress[i] > item.value) r.flag = 1'b1;
            end
            default: begin
                if (cfg_prio && item.value != '0 && (ID_W'(item.value[31:8]) % k) == '0)
                    r.flag = 1'b1;
            end
        endcase
        r.max_progress = table_peak();
        return r;
    endfunction

    always @(posedge clk) begin : check_result
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: id %h flag %b adv %b max %h",
                             out_data.issued_id, out_data.flag, out_data.epoch_advanced,
                             out_data.max_progress);
            end else begin
                want = pending_results.pop_front();
                if (out_data !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("exp id %h f %b a %b max %h got id %h f %b a %b max %h",
                                 want.issued_id, want.flag, want.epoch_advanced,
                                 want.max_progress, out_data.issued_id, out_data.flag,
                                 out_data.epoch_advanced, out_data.max_progress);
                end
            end
        end
    end

    // Receiver back-pressure in random bursts
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    task automatic send_item(input t_func f, input logic [CORE_ID_W-1:0] core,
                             input logic [ID_W-1:0] value);
        t_in_item item;
        int       gap;
        item.func    = f;
        item.core_id = core;
        item.value   = value;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(predict_result(item));
    endtask

    // Drop valid, wait for every result, then let the block settle
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_BACKOFF:  cfg_backoff = data[BACKOFF_W-1:0];
            CFG_SLOT_PCT: cfg_pct     = data[PCT_W-1:0];
            CFG_PRIORITY: cfg_prio    = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [BACKOFF_W-1:0] backoff, input logic [PCT_W-1:0] pct,
                              input logic prio);
        drain_pipeline();
        write_reg(CFG_BACKOFF, backoff);
        // junk in the unused upper bits must be ignored
        write_reg(CFG_SLOT_PCT, {(CFG_DATA_W - PCT_W)'($urandom), pct});
        write_reg(CFG_PRIORITY, {(CFG_DATA_W - 1)'($urandom), prio});
        write_reg(CFG_NONE, CFG_DATA_W'($urandom));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int                   pick;
        int unsigned          n;
        logic [CORE_ID_W-1:0] core;
        logic [ID_W-1:0]      value, peak, k;
        for (int i = 0; i < count; i++) begin
            pick  = $urandom_range(0, 9);
            core  = CORE_ID_W'($urandom);
            peak  = table_peak();
            k     = period_of(cfg_pct);
            value = {$urandom, $urandom};
            if (pick < 4) begin
                case ($urandom_range(0, 9))
                    0: ;
                    1, 2: value = (core_progress[core] < 4) ? core_progress[core]
                                  : core_progress[core] - ID_W'($urandom_range(0, 3));
                    3: value = {core_progress[core][63:32] + 32'd1, 24'($urandom), 8'($urandom)};
                    default: value = {peak[63:32] + 32'($urandom_range(0, 1)), 24'($urandom),
                                      8'($urandom)};
                endcase
                send_item(FUNC_UPDATE, core, value);
            end else if (pick < 6) begin
                send_item(FUNC_ALLOCATE, core, value);
            end else if (pick < 8) begin
                case ($urandom_range(0, 4))
                    0: ;
                    1: value = core_progress[core];
                    2: value = peak;
                    default: value = peak + ID_W'($urandom_range(0, 2)) - 1;
                endcase
                send_item(FUNC_CHECK_PASSED, core, value);
            end else begin
                case ($urandom_range(0, 7))
                    0, 1: ;
                    2: value = '0;
                    3: value = last_id;
                    default: begin
                        n     = $urandom_range(0, 32'(ID_W'(24'hFFFFFF) / k));
                        value = {32'($urandom), 24'(ID_W'(n) * k), 8'($urandom)};
                    end
                endcase
                send_item(FUNC_CHECK_SLOT, core, value);
            end
        end
    endtask

    task automatic test_reset_state();
        send_item(FUNC_CHECK_SLOT, 3'd0, '0);
        send_item(FUNC_CHECK_SLOT, 3'd5, {32'd0, 24'd6, 8'd0});
        send_item(FUNC_CHECK_PASSED, 3'd0, '0);
        send_item(FUNC_ALLOCATE, 3'd7, '1);
        send_item(FUNC_CHECK_PASSED, 3'd7, '1);
    endtask

    task automatic test_progress_update();
        send_item(FUNC_UPDATE, 3'd0, {32'd0, 24'd5, 8'd3});
        send_item(FUNC_UPDATE, 3'd0, {32'd1, 24'd2, 8'd1});
        send_item(FUNC_UPDATE, 3'd1, {32'd2, 24'd9, 8'd4});
        send_item(FUNC_UPDATE, 3'd0, {32'd0, 24'd7, 8'd0});
        send_item(FUNC_UPDATE, 3'd7, {32'd3, 24'h800000, 8'h80});
        send_item(FUNC_UPDATE, 3'd0, {32'd5, 24'd1, 8'd2});
        send_item(FUNC_CHECK_PASSED, 3'd4, {32'd5, 24'd1, 8'd2});
        send_item(FUNC_CHECK_PASSED, 3'd4, {32'd5, 24'd1, 8'd1});
    endtask

    task automatic test_sequence_spill();
        set_config(24'hFFFFFF, PCT_W'(100), 1'b1);
        send_item(FUNC_UPDATE, 3'd2, {32'd9, 24'hFFFFFF, 8'hFF});
        send_item(FUNC_ALLOCATE, 3'd2, '0);
        send_item(FUNC_ALLOCATE, 3'd6, '0);
        send_item(FUNC_CHECK_SLOT, 3'd1, {32'd9, 24'hFFFFFE, 8'h00});
        send_item(FUNC_CHECK_SLOT, 3'd1, '1);
    endtask

    task automatic test_slot_settings();
        set_config(BACKOFF_RESET, PCT_RESET, PRIO_RESET);
        run_random(60);
        set_config('0, PCT_W'(1), 1'b1);
        run_random(60);
        set_config(24'hFFFFFF, PCT_W'(100), 1'b1);
        run_random(60);
        set_config(BACKOFF_W'($urandom_range(0, 5000)), '0, 1'b0);
        run_random(60);
        set_config(BACKOFF_W'($urandom), PCT_W'($urandom_range(101, 127)), 1'b1);
        run_random(60);
    endtask

    task automatic test_steady_stream();
        set_config(BACKOFF_W'($urandom), PCT_W'($urandom_range(1, 100)), 1'b1);
        idle_on = 1'b0;
        run_random(100);
    endtask

    task automatic test_saturation();
        send_item(FUNC_UPDATE, 3'd3, '1);
        send_item(FUNC_ALLOCATE, 3'd3, '0);
        send_item(FUNC_CHECK_PASSED, 3'd0, '1);
        send_item(FUNC_CHECK_SLOT, 3'd0, '1);
        send_item(FUNC_UPDATE, 3'd4, '1);
    endtask

    initial begin
        for (int i = 0; i < NUM_CORES; i++) core_progress[i] = '0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_BACKOFF;
        cfg_data  <= '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_progress_update();
        test_sequence_spill();
        test_slot_settings();
        test_steady_stream();
        test_saturation();

        drain_pipeline();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("serial_id_slot_allocator_tb passed");
        else
            $display("serial_id_slot_allocator_tb failed");
        $finish;
    end

endmodule
